FILE: sv/kcd_pkg.sv
// ----------------------------------------------------------------------------
// kcd_pkg
// shared types and constants for the key click detector
// ----------------------------------------------------------------------------
package kcd_pkg;

   localparam int NUM_KEYS_DEF    = 16;
   localparam int COUNT_WIDTH_DEF = 8;

   localparam int KEY_W   = 4;
   localparam int EVENT_W = 2;
   localparam int THR_W   = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;

   localparam logic [THR_W-1:0] LONG_PRESS_RST  = 8'd50;
   localparam logic [THR_W-1:0] DOUBLE_WAIT_RST = 8'd25;
   localparam logic             PRESSED_LVL_RST = 1'b0;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LONG_PRESS  = 2'd0,
      CSR_DOUBLE_WAIT = 2'd1,
      CSR_PRESSED_LVL = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      PH_IDLE     = 3'd0,
      PH_DEBOUNCE = 3'd1,
      PH_PRESS    = 3'd2,
      PH_LONG     = 3'd3,
      PH_WAIT     = 3'd4,
      PH_SECOND   = 3'd5
   } phase_type;

   typedef enum logic [EVENT_W-1:0] {
      EV_NONE   = 2'd0,
      EV_SINGLE = 2'd1,
      EV_DOUBLE = 2'd2,
      EV_LONG   = 2'd3
   } event_type;

endpackage

FILE: sv/key_click_detector.sv
// ----------------------------------------------------------------------------
// key_click_detector
// per-key single, double and long press classifier
// ----------------------------------------------------------------------------
// usage:
//   req channel carries one scan tick for one key (key index, raw pin level).
//   rsp channel returns one transaction per request: the key index echoed
//   and an event code (none, single click, double click, long press).
//   csr port writes long press ticks, double click wait ticks and the
//   pressed pin level; write only while no transaction is in flight.
// order: a request is registered, then classified into the response
//   register; a stalled response holds it in the request register.
// throughput: one transaction per cycle unless stalled; the per-key phase
//   and tick counter update is a single read-modify-write of key state flops.
// reset: all keys return to idle with a zero counter, registers take their
//   default values and both channels are empty.
// stall: a stalled response holds; the request register still fills, and
//   req_stall rises only when both the request and response registers are
//   full and the response is stalled.
// ----------------------------------------------------------------------------
module key_click_detector #(
   parameter int NUM_KEYS    = kcd_pkg::NUM_KEYS_DEF,
   parameter int COUNT_WIDTH = kcd_pkg::COUNT_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [kcd_pkg::KEY_W-1:0]     req_key_index,
   input  logic                          req_pin_level,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [kcd_pkg::KEY_W-1:0]     rsp_key_id,
   output logic [kcd_pkg::EVENT_W-1:0]   rsp_event_code,
   input  logic                          csr_write_en,
   input  logic [kcd_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [kcd_pkg::CSR_DATA_W-1:0] csr_data
);
   import kcd_pkg::*;

   localparam int IDX_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
   localparam int EXT_W = ((IDX_W > KEY_W) ? IDX_W : KEY_W) + 1;
   localparam int LIM_W = (COUNT_WIDTH > THR_W) ? COUNT_WIDTH : THR_W;
   localparam logic [LIM_W-1:0] CNT_MAX = LIM_W'({COUNT_WIDTH{1'b1}});
   localparam logic [EXT_W-1:0] KEYS_EXT = EXT_W'(NUM_KEYS);

   // configuration
   logic [THR_W-1:0] long_ff, wait_ff;
   logic             level_ff;

   // request and response registers
   logic             in_vld_ff, in_vld_in;
   logic [KEY_W-1:0] in_key_ff;
   logic             in_pin_ff;
   logic             out_vld_ff, out_vld_in;
   logic [KEY_W-1:0] out_key_ff;
   event_type        out_ev_ff;

   // per-key state
   phase_type              phase_ff [NUM_KEYS];
   logic [COUNT_WIDTH-1:0] count_ff [NUM_KEYS];

   logic                   req_take, advance, in_range, pressed;
   logic [EXT_W-1:0]       key_ext;
   logic [IDX_W-1:0]       key_idx;
   logic [LIM_W-1:0]       long_ext, wait_ext;
   logic [COUNT_WIDTH-1:0] lim_long, lim_wait, cnt_cur, cnt_in;
   phase_type              ph_cur, ph_in;
   event_type              ev_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         long_ff  <= LONG_PRESS_RST;
         wait_ff  <= DOUBLE_WAIT_RST;
         level_ff <= PRESSED_LVL_RST;
      end else if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            CSR_LONG_PRESS:  long_ff  <= csr_data;
            CSR_DOUBLE_WAIT: wait_ff  <= csr_data;
            CSR_PRESSED_LVL: level_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // handshake
   assign advance   = in_vld_ff & ~(out_vld_ff & rsp_stall);
   assign req_stall = in_vld_ff & out_vld_ff & rsp_stall;
   assign req_take  = req_valid & ~req_stall;
   assign in_vld_in = req_take | (in_vld_ff & ~advance);
   assign out_vld_in = advance | (out_vld_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_key_ff <= req_key_index;
         in_pin_ff <= req_pin_level;
      end
   end

   // key lookup and thresholds
   assign key_ext  = EXT_W'(in_key_ff);
   assign in_range = key_ext < KEYS_EXT;
   assign key_idx  = key_ext[IDX_W-1:0];
   assign pressed  = in_pin_ff == level_ff;
   assign ph_cur   = phase_ff[key_idx];
   assign cnt_cur  = count_ff[key_idx];
   assign long_ext = LIM_W'(long_ff);
   assign wait_ext = LIM_W'(wait_ff);
   assign lim_long = COUNT_WIDTH'((long_ext > CNT_MAX) ? CNT_MAX : long_ext);
   assign lim_wait = COUNT_WIDTH'((wait_ext > CNT_MAX) ? CNT_MAX : wait_ext);

   // next phase and counter
   always_comb begin
      ph_in  = ph_cur;
      cnt_in = cnt_cur;
      case (ph_cur)
         PH_IDLE: ph_in = pressed ? PH_DEBOUNCE : PH_IDLE;
         PH_DEBOUNCE: ph_in = pressed ? PH_PRESS : PH_IDLE;
         PH_PRESS: begin
            if (pressed && cnt_cur >= lim_long) begin
               ph_in  = PH_LONG;
               cnt_in = '0;
            end else if (pressed) begin
               cnt_in = cnt_cur + 1'b1;
            end else begin
               ph_in  = PH_WAIT;
               cnt_in = '0;
            end
         end
         PH_LONG: begin
            cnt_in = '0;
            if (!pressed) ph_in = PH_IDLE;
         end
         PH_WAIT: begin
            if (!pressed && cnt_cur >= lim_wait) begin
               ph_in  = PH_IDLE;
               cnt_in = '0;
            end else if (!pressed) begin
               cnt_in = cnt_cur + 1'b1;
            end else begin
               ph_in  = PH_SECOND;
               cnt_in = '0;
            end
         end
         PH_SECOND: begin
            if (pressed && cnt_cur >= lim_long) begin
               ph_in  = PH_LONG;
               cnt_in = '0;
            end else if (pressed) begin
               cnt_in = cnt_cur + 1'b1;
            end else begin
               ph_in  = PH_IDLE;
               cnt_in = '0;
            end
         end
         default: begin
            ph_in  = PH_IDLE;
            cnt_in = '0;
         end
      endcase
   end

   // event output
   always_comb begin
      ev_in = EV_NONE;
      if (in_range) begin
         case (ph_cur)
            PH_LONG:   if (!pressed) ev_in = EV_LONG;
            PH_WAIT:   if (!pressed && cnt_cur >= lim_wait) ev_in = EV_SINGLE;
            PH_SECOND: begin
               if (pressed && cnt_cur >= lim_long) ev_in = EV_SINGLE;
               else if (!pressed) ev_in = EV_DOUBLE;
            end
            default:   ev_in = EV_NONE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_KEYS; i++) begin
            phase_ff[i] <= PH_IDLE;
            count_ff[i] <= '0;
         end
      end else if (advance && in_range) begin
         phase_ff[key_idx] <= ph_in;
         count_ff[key_idx] <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_key_ff <= in_key_ff;
         out_ev_ff  <= ev_in;
      end
   end

   assign rsp_valid      = out_vld_ff;
   assign rsp_key_id     = out_key_ff;
   assign rsp_event_code = out_ev_ff;

endmodule
